/* rtl/assert_macros.svh */
// assertion macros for the rtl decoder core
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked check, masked while reset is high
`define ASSERT_CLK_RST(lbl, clk_s, rst_s, prop, msg) \
  lbl: assert property (@(posedge clk_s) disable iff (rst_s) prop) else $error(msg);

// clocked check that also holds during reset
`define ASSERT_CLK(lbl, clk_s, prop, msg) \
  lbl: assert property (@(posedge clk_s) prop) else $error(msg);

`endif

/* rtl/pprcd_pkg.sv */
// types, constants and duration matching helpers for the pulse pair decoder
package pprcd_pkg;

  localparam int DUR_W  = 17;
  localparam int TIME_W = 16;
  localparam int LEN_W  = 6;
  localparam int CODE_W = 32;

  localparam logic [1:0] REG_SHORT_TIME  = 2'd0;
  localparam logic [1:0] REG_LONG_TIME   = 2'd1;
  localparam logic [1:0] REG_TOLERANCE   = 2'd2;
  localparam logic [1:0] REG_CODE_LENGTH = 2'd3;

  localparam logic [TIME_W-1:0] SHORT_TIME_RST  = 16'd500;
  localparam logic [TIME_W-1:0] LONG_TIME_RST   = 16'd1500;
  localparam logic [TIME_W-1:0] TOLERANCE_RST   = 16'd250;
  localparam logic [LEN_W-1:0]  CODE_LENGTH_RST = 6'd10;
  localparam logic [LEN_W-1:0]  MIN_CODE_BITS   = 6'd5;

  typedef logic [DUR_W-1:0] mag_t;

  // absolute value of a signed duration, 65536 fits unsigned
  function automatic mag_t dur_mag(input logic signed [DUR_W-1:0] d);
    mag_t m;
    if (d[DUR_W-1]) begin
      m = ~d + 17'd1;
    end else begin
      m = d;
    end
    return m;
  endfunction

  // nominal - tol <= mag <= nominal + tol, without signed math
  function automatic logic near_time(input mag_t mag, input logic [TIME_W-1:0] nominal,
                                     input logic [TIME_W-1:0] tol);
    logic [DUR_W:0] lo_side;
    logic [DUR_W:0] hi_side;
    lo_side = {1'b0, mag} + {2'b00, tol};
    hi_side = {2'b00, nominal} + {2'b00, tol};
    return (lo_side >= {2'b00, nominal}) && ({1'b0, mag} <= hi_side);
  endfunction

endpackage

/* rtl/pulse_pair_remote_code_decoder_core.sv */
// pulse pair remote code decoder: duration stream in, decoded code result out
//
//  channel  | handshake            | payload
//  ---------+----------------------+------------------------------
//  in       | in_valid / in_ready  | duration (s17), last
//  out      | out_valid / out_ready| found, code[31:0]
//  config   | write_en             | write_index[1:0], write_data[15:0]
//
// one duration request per cycle while in_ready is high; decode state and the result
// register update at the same edge, so a result shows in the cycle after its request.
// in_ready drops only while a result is held and out_ready is low.
// rst is synchronous: registers go to their defaults, capture state clears.
module pulse_pair_remote_code_decoder_core
  import pprcd_pkg::*;
#(
  parameter int MAX_CODE_BITS = 32
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     write_en,
  input  logic [1:0]               write_index,
  input  logic [TIME_W-1:0]        write_data,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  logic signed [DUR_W-1:0]  duration,
  input  logic                     last,
  output logic                     out_valid,
  input  logic                     out_ready,
  output logic                     found,
  output logic [CODE_W-1:0]        code
);

  `include "assert_macros.svh"

  localparam int CNT_W = $clog2(MAX_CODE_BITS + 1);
  localparam int TGT_W = (CNT_W > LEN_W) ? CNT_W : LEN_W;

  logic [TIME_W-1:0] short_time;
  logic [TIME_W-1:0] long_time;
  logic [TIME_W-1:0] tolerance;
  logic [LEN_W-1:0]  code_length;

  logic              pulse_pending, pulse_pending_next;
  logic [TIME_W-1:0] held_pulse, held_pulse_next;
  logic [CODE_W-1:0] shift_code, shift_code_next;
  logic [CNT_W-1:0]  bits_seen, bits_seen_next;
  logic              at_capture_start, at_capture_start_next;
  logic              decided, decided_next;

  logic              res_valid;
  logic              res_found;
  logic [CODE_W-1:0] res_code;
  logic              accept;
  logic [TGT_W-1:0]  target;
  logic [TGT_W-1:0]  len_ext;
  mag_t              dmag;
  logic              short_long;
  logic              long_short;

  assign in_ready = !out_valid || out_ready;
  assign accept   = in_valid && in_ready;

  // clamp code length to [5, MAX_CODE_BITS]
  assign len_ext = TGT_W'(code_length);
  always_comb begin
    if (code_length < MIN_CODE_BITS) begin
      target = TGT_W'(MIN_CODE_BITS);
    end else if (len_ext > TGT_W'(MAX_CODE_BITS)) begin
      target = TGT_W'(MAX_CODE_BITS);
    end else begin
      target = len_ext;
    end
  end

  assign dmag       = dur_mag(duration);
  assign short_long = near_time({1'b0, held_pulse}, short_time, tolerance) &&
                      near_time(dmag, long_time, tolerance);
  assign long_short = near_time({1'b0, held_pulse}, long_time, tolerance) &&
                      near_time(dmag, short_time, tolerance);

  always_comb begin
    pulse_pending_next    = pulse_pending;
    held_pulse_next       = held_pulse;
    shift_code_next       = shift_code;
    bits_seen_next        = bits_seen;
    at_capture_start_next = at_capture_start;
    decided_next          = decided;
    res_valid             = 1'b0;
    res_found             = 1'b0;
    res_code              = '0;
    if (!decided) begin
      if (!pulse_pending) begin
        if (!last) begin
          if (duration[DUR_W-1]) begin
            if (at_capture_start) begin
              at_capture_start_next = 1'b0;
            end else begin
              decided_next = 1'b1;
              res_valid    = 1'b1;
            end
          end else begin
            held_pulse_next       = duration[TIME_W-1:0];
            pulse_pending_next    = 1'b1;
            at_capture_start_next = 1'b0;
          end
        end
      end else begin
        pulse_pending_next    = 1'b0;
        at_capture_start_next = 1'b0;
        if (short_long) begin
          shift_code_next = {shift_code[CODE_W-2:0], 1'b0};
          bits_seen_next  = bits_seen + CNT_W'(1);
        end else if (long_short) begin
          shift_code_next = {shift_code[CODE_W-2:0], 1'b1};
          bits_seen_next  = bits_seen + CNT_W'(1);
        end else begin
          shift_code_next = '0;
          bits_seen_next  = '0;
        end
        if (TGT_W'(bits_seen_next) >= target) begin
          decided_next = 1'b1;
          res_valid    = 1'b1;
          res_found    = 1'b1;
          res_code     = shift_code_next;
        end
      end
    end
    if (last) begin
      if (!decided_next) begin
        res_valid = 1'b1;
        res_found = 1'b0;
        res_code  = '0;
      end
      pulse_pending_next    = 1'b0;
      held_pulse_next       = '0;
      shift_code_next       = '0;
      bits_seen_next        = '0;
      at_capture_start_next = 1'b1;
      decided_next          = 1'b0;
    end
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      short_time  <= SHORT_TIME_RST;
      long_time   <= LONG_TIME_RST;
      tolerance   <= TOLERANCE_RST;
      code_length <= CODE_LENGTH_RST;
    end else if (write_en) begin
      case (write_index)
        REG_SHORT_TIME:  short_time  <= write_data;
        REG_LONG_TIME:   long_time   <= write_data;
        REG_TOLERANCE:   tolerance   <= write_data;
        REG_CODE_LENGTH: code_length <= write_data[LEN_W-1:0];
        default: ;
      endcase
    end
  end

  // capture state
  always_ff @(posedge clk) begin
    if (rst) begin
      pulse_pending    <= 1'b0;
      shift_code       <= '0;
      bits_seen        <= '0;
      at_capture_start <= 1'b1;
      decided          <= 1'b0;
    end else if (accept) begin
      pulse_pending    <= pulse_pending_next;
      shift_code       <= shift_code_next;
      bits_seen        <= bits_seen_next;
      at_capture_start <= at_capture_start_next;
      decided          <= decided_next;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      held_pulse <= held_pulse_next;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (accept && res_valid) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && res_valid) begin
      found <= res_found;
      code  <= res_code;
    end
  end

  `ASSERT_CLK_RST(a_notfound_zero, clk, rst, out_valid && !found |-> code == '0,
                  "not-found result carries a nonzero code")
  `ASSERT_CLK_RST(a_decided_no_pulse, clk, rst, decided |-> !pulse_pending,
                  "pulse held after decision")
  `ASSERT_CLK_RST(a_last_clears, clk, rst,
                  accept && last |=> at_capture_start && !decided && bits_seen == '0,
                  "capture state not cleared after last request")
  `ASSERT_CLK_RST(a_mid_result_decides, clk, rst,
                  accept && !last && res_valid |=> decided && out_valid,
                  "result without decision")
  `ASSERT_CLK(a_reset_idle, clk, rst |=> !out_valid && at_capture_start,
              "reset did not clear result and capture state")

endmodule

/* sim/pulse_pair_remote_code_decoder_checker.sv */
// checker for the pulse pair decoder: tracks registers, predicts results, compares outputs
`timescale 1ns / 100ps

module pulse_pair_remote_code_decoder_checker
  import pprcd_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    write_en,
  input  logic [1:0]              write_index,
  input  logic [TIME_W-1:0]       write_data,
  input  logic                    in_valid,
  input  logic                    in_ready,
  input  logic signed [DUR_W-1:0] duration,
  input  logic                    last,
  input  logic                    out_valid,
  input  logic                    out_ready,
  input  logic                    found,
  input  logic [CODE_W-1:0]       code,
  output int                      fail_count,
  output int                      outstanding
);

  localparam int MAX_BITS = 32;

  typedef struct packed {
    logic              found;
    logic [CODE_W-1:0] code;
  } code_result_t;

  code_result_t awaited_codes[$];

  logic [TIME_W-1:0]       short_nom;
  logic [TIME_W-1:0]       long_nom;
  logic [TIME_W-1:0]       tol_width;
  logic [LEN_W-1:0]        len_reg;

  logic                    pulse_pending;
  logic signed [DUR_W-1:0] held_pulse;
  logic [CODE_W-1:0]       shift_code;
  int                      bits_seen;
  logic                    at_start;
  logic                    decided;

  function automatic bit matches_nominal(input logic signed [DUR_W-1:0] d,
                                         input logic [TIME_W-1:0] nominal);
    int mag;
    int lo;
    int hi;
    mag = (d < 0) ? -int'(d) : int'(d);
    lo = int'(nominal) - int'(tol_width);
    hi = int'(nominal) + int'(tol_width);
    return (mag >= lo) && (mag <= hi);
  endfunction

  task automatic capture_clear();
    pulse_pending = 1'b0;
    held_pulse = '0;
    shift_code = '0;
    bits_seen = 0;
    at_start = 1'b1;
    decided = 1'b0;
  endtask

  task automatic push_code(input logic hit, input logic [CODE_W-1:0] value);
    code_result_t res;
    res.found = hit;
    res.code = value;
    awaited_codes.push_back(res);
  endtask

  // one duration request through the decode state
  task automatic decode_duration(input logic signed [DUR_W-1:0] d, input logic is_last);
    int target;
    target = int'(len_reg);
    if (target < int'(MIN_CODE_BITS)) target = int'(MIN_CODE_BITS);
    if (target > MAX_BITS) target = MAX_BITS;
    if (!decided) begin
      if (!pulse_pending) begin
        if (!is_last) begin
          if (d < 0) begin
            if (at_start) begin
              at_start = 1'b0;
            end else begin
              decided = 1'b1;
              push_code(1'b0, '0);
            end
          end else begin
            held_pulse = d;
            pulse_pending = 1'b1;
            at_start = 1'b0;
          end
        end
      end else begin
        pulse_pending = 1'b0;
        at_start = 1'b0;
        if (matches_nominal(held_pulse, short_nom) && matches_nominal(d, long_nom)) begin
          shift_code = shift_code << 1;
          bits_seen++;
        end else if (matches_nominal(held_pulse, long_nom) && matches_nominal(d, short_nom)) begin
          shift_code = (shift_code << 1) | 32'd1;
          bits_seen++;
        end else begin
          shift_code = '0;
          bits_seen = 0;
        end
        if (bits_seen >= target) begin
          decided = 1'b1;
          push_code(1'b1, shift_code);
        end
      end
    end
    if (is_last) begin
      if (!decided) push_code(1'b0, '0);
      capture_clear();
    end
  endtask

  always @(posedge clk) begin
    code_result_t exp_res;
    if (rst) begin
      short_nom = SHORT_TIME_RST;
      long_nom = LONG_TIME_RST;
      tol_width = TOLERANCE_RST;
      len_reg = CODE_LENGTH_RST;
      capture_clear();
      awaited_codes.delete();
      fail_count = 0;
    end else begin
      if (write_en) begin
        case (write_index)
          REG_SHORT_TIME:  short_nom = write_data;
          REG_LONG_TIME:   long_nom = write_data;
          REG_TOLERANCE:   tol_width = write_data;
          REG_CODE_LENGTH: len_reg = write_data[LEN_W-1:0];
          default: ;
        endcase
      end
      if (out_valid && out_ready) begin
        if (awaited_codes.size() == 0) begin
          $display("%0t ns: result with none expected, actual found %0b code %h",
                   $time, found, code);
          fail_count++;
        end else begin
          exp_res = awaited_codes.pop_front();
          if (found !== exp_res.found) begin
            $display("%0t ns: found mismatch, expected %0b actual %0b",
                     $time, exp_res.found, found);
            fail_count++;
          end
          if (code !== exp_res.code) begin
            $display("%0t ns: code mismatch, expected %h actual %h",
                     $time, exp_res.code, code);
            fail_count++;
          end
        end
      end
      if (in_valid && in_ready) decode_duration(duration, last);
    end
    outstanding = awaited_codes.size();
  end

endmodule

/* sim/pulse_pair_remote_code_decoder_core_tb.sv */
// testbench top for the pulse pair decoder: clock, reset, stimulus and verdict
`timescale 1ns / 100ps

module pulse_pair_remote_code_decoder_core_tb
  import pprcd_pkg::*;
();

  logic                    clk = 1'b0;
  logic                    rst = 1'b1;
  logic                    write_en = 1'b0;
  logic [1:0]              write_index = '0;
  logic [TIME_W-1:0]       write_data = '0;
  logic                    in_valid = 1'b0;
  logic                    in_ready;
  logic signed [DUR_W-1:0] duration = '0;
  logic                    last = 1'b0;
  logic                    out_valid;
  logic                    out_ready = 1'b0;
  logic                    found;
  logic [CODE_W-1:0]       code;

  int fail_count;
  int outstanding;

  int short_cfg = 500;
  int long_cfg = 1500;
  int tol_cfg = 250;
  int len_cfg = 10;
  int sent = 0;
  int rx_hold = 0;
  bit tx_quiet = 1'b0;
  bit rx_quiet = 1'b0;

  pulse_pair_remote_code_decoder_core dut (
    .clk(clk), .rst(rst),
    .write_en(write_en), .write_index(write_index), .write_data(write_data),
    .in_valid(in_valid), .in_ready(in_ready), .duration(duration), .last(last),
    .out_valid(out_valid), .out_ready(out_ready), .found(found), .code(code)
  );

  pulse_pair_remote_code_decoder_checker decode_check (
    .clk(clk), .rst(rst),
    .write_en(write_en), .write_index(write_index), .write_data(write_data),
    .in_valid(in_valid), .in_ready(in_ready), .duration(duration), .last(last),
    .out_valid(out_valid), .out_ready(out_ready), .found(found), .code(code),
    .fail_count(fail_count), .outstanding(outstanding)
  );

  always #6 clk = ~clk;

  initial begin
    #12_000_000;
    $display("pulse_pair_remote_code_decoder_core regression: fail");
    $finish;
  end

  function automatic int eff_bits();
    if (len_cfg < 5) return 5;
    if (len_cfg > 32) return 32;
    return len_cfg;
  endfunction

  function automatic int any_duration();
    return int'($urandom_range(0, 131071)) - 65536;
  endfunction

  // magnitude near a nominal time: inside, on the edges, or just outside
  function automatic int near_value(input int nominal);
    int pick;
    int off;
    int v;
    pick = $urandom_range(0, 99);
    if (pick < 8) off = tol_cfg;
    else if (pick < 16) off = -tol_cfg;
    else if (pick < 19) off = $urandom_range(0, 1) ? tol_cfg + 1 : -tol_cfg - 1;
    else off = int'($urandom_range(0, 2 * tol_cfg)) - tol_cfg;
    v = nominal + off;
    if (v < 0) v = 0;
    if (v > 65535) v = 65535;
    return v;
  endfunction

  task automatic write_reg(input logic [1:0] idx, input int val);
    write_en <= 1'b1;
    write_index <= idx;
    write_data <= val[TIME_W-1:0];
    case (idx)
      REG_SHORT_TIME:  short_cfg = val;
      REG_LONG_TIME:   long_cfg = val;
      REG_TOLERANCE:   tol_cfg = val;
      REG_CODE_LENGTH: len_cfg = val & 63;
      default: ;
    endcase
    @(posedge clk);
  endtask

  task automatic load_setting(input int s, input int l, input int t, input int n);
    write_reg(REG_SHORT_TIME, s);
    write_reg(REG_LONG_TIME, l);
    write_reg(REG_TOLERANCE, t);
    write_reg(REG_CODE_LENGTH, n);
    write_en <= 1'b0;
  endtask

  task automatic send_item(input int value, input bit is_last);
    int gap;
    gap = (tx_quiet || $urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 17);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    duration <= value[DUR_W-1:0];
    last <= is_last;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sent++;
  endtask

  // one pulse/gap request pair for a bit, gap polarity mostly low
  task automatic send_bit(input bit b, input bit end_here);
    int pulse;
    int gap;
    pulse = near_value(b ? long_cfg : short_cfg);
    gap = near_value(b ? short_cfg : long_cfg);
    if ($urandom_range(0, 9) != 0) gap = -gap;
    send_item(pulse, 1'b0);
    send_item(gap, end_here);
  endtask

  task automatic send_capture();
    int kind;
    int nb;
    int k;
    bit end_on_gap;
    kind = $urandom_range(0, 99);
    if (kind < 60) begin
      if ($urandom_range(0, 1)) send_item(-int'($urandom_range(1, 65536)), 1'b0);
      if ($urandom_range(0, 3) == 0) begin
        repeat ($urandom_range(1, 3)) begin
          send_item(int'($urandom_range(0, 65535)), 1'b0);
          send_item(any_duration(), 1'b0);
        end
      end
      nb = eff_bits();
      k = $urandom_range(0, 9);
      if (k == 0) nb = nb - 1;
      else if (k == 1) nb = nb + $urandom_range(1, 3);
      end_on_gap = 1'($urandom_range(0, 1));
      for (int i = 0; i < nb; i++) begin
        send_bit(1'($urandom_range(0, 1)), end_on_gap && (i == nb - 1));
      end
      if (!end_on_gap) begin
        repeat ($urandom_range(0, 2)) send_item(any_duration(), 1'b0);
        send_item(any_duration(), 1'b1);
      end
    end else if (kind < 75) begin
      repeat ($urandom_range(0, eff_bits() - 1)) send_bit(1'($urandom_range(0, 1)), 1'b0);
      case ($urandom_range(0, 2))
        0: send_item(-int'($urandom_range(1, 65536)), 1'b0);
        1: begin
          send_item(0, 1'b0);
          send_item(-near_value(long_cfg), 1'b0);
        end
        default: begin
          send_item(near_value(short_cfg), 1'b0);
          send_item(-near_value(short_cfg), 1'b0);
        end
      endcase
      repeat ($urandom_range(0, eff_bits())) send_bit(1'($urandom_range(0, 1)), 1'b0);
      send_item(any_duration(), 1'b1);
    end else if (kind < 90) begin
      k = $urandom_range(1, 6);
      for (int i = 0; i < k; i++) send_item(any_duration(), i == k - 1);
    end else begin
      repeat ($urandom_range(0, eff_bits() - 1)) send_bit(1'($urandom_range(0, 1)), 1'b0);
      send_item(near_value(short_cfg), 1'b1);
    end
  endtask

  // hold requests back until every expected result is out
  task automatic settle(input int extra);
    in_valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (extra) @(posedge clk);
  endtask

  initial begin
    int stall;
    while (rst) @(posedge clk);
    forever begin
      if (rx_hold > 0) begin
        out_ready <= 1'b0;
        repeat (rx_hold) @(posedge clk);
        rx_hold = 0;
      end
      stall = (rx_quiet || $urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 17);
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      @(posedge clk);
      while (!out_valid) @(posedge clk);
    end
  end

  initial begin
    int budget;
    int s;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // short codes for the directed requests
    write_reg(REG_CODE_LENGTH, 0);
    write_en <= 1'b0;

    // negative lead skipped, window edges, positive gap, decision on last
    send_item(-65536, 1'b0);
    send_item(750, 1'b0);
    send_item(-1250, 1'b0);
    send_item(1750, 1'b0);
    send_item(-250, 1'b0);
    send_item(250, 1'b0);
    send_item(1750, 1'b0);
    send_item(1250, 1'b0);
    send_item(-750, 1'b0);
    send_item(500, 1'b0);
    send_item(-1500, 1'b1);
    // zero pulse, later negative pulse, swallowed tail
    send_item(0, 1'b0);
    send_item(-1500, 1'b0);
    send_item(500, 1'b0);
    send_item(-1500, 1'b0);
    send_item(-500, 1'b0);
    send_item(65535, 1'b0);
    send_item(65535, 1'b1);
    // just outside the window, then unpaired final pulse
    send_item(1501, 1'b0);
    send_item(-1751, 1'b0);
    send_item(1500, 1'b1);
    // lone last request in pulse position
    send_item(-65536, 1'b1);

    for (int ph = 0; ph < 8; ph++) begin
      settle(4);
      case (ph)
        0: load_setting(500, 1500, 250, 10);
        1: begin
          load_setting(300, 900, 100, 0);
          rx_hold = 400;
        end
        2: load_setting(1, 2, 0, 5);
        3: load_setting(65535, 65534, 0, 6);
        4: load_setting(400, 1200, 65535, 63);
        7: load_setting(1000, 1200, 150, 12);
        default: begin
          s = $urandom_range(20, 4000);
          load_setting(s, s * $urandom_range(2, 4), $urandom_range(0, s / 2),
                       $urandom_range(5, 24));
        end
      endcase
      tx_quiet = ($urandom_range(0, 3) == 0);
      rx_quiet = ($urandom_range(0, 3) == 0);
      budget = sent + ((ph == 4) ? 100 : 175);
      while (sent < budget) send_capture();
    end

    settle(8);
    if (fail_count == 0 && outstanding == 0) begin
      $display("pulse_pair_remote_code_decoder_core regression: pass");
    end else begin
      $display("pulse_pair_remote_code_decoder_core regression: fail");
    end
    $finish;
  end

endmodule

/* filelist.f */
+incdir+rtl
rtl/pprcd_pkg.sv
rtl/pulse_pair_remote_code_decoder_core.sv
sim/pulse_pair_remote_code_decoder_checker.sv
sim/pulse_pair_remote_code_decoder_core_tb.sv
